### rtl/core/tun_pkg.sv
// Shared types and constants for the triangle unit normal block.
package tun_pkg;

  localparam int FIELD_W         = 16;
  localparam int COORD_WIDTH_DEF = 16;
  localparam int NORMAL_FRAC_DEF = 14;

  typedef struct packed {
    logic signed [FIELD_W-1:0] first_x;
    logic signed [FIELD_W-1:0] first_y;
    logic signed [FIELD_W-1:0] first_z;
    logic signed [FIELD_W-1:0] second_x;
    logic signed [FIELD_W-1:0] second_y;
    logic signed [FIELD_W-1:0] second_z;
    logic signed [FIELD_W-1:0] third_x;
    logic signed [FIELD_W-1:0] third_y;
    logic signed [FIELD_W-1:0] third_z;
  } vertex_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] normal_x;
    logic signed [FIELD_W-1:0] normal_y;
    logic signed [FIELD_W-1:0] normal_z;
    logic                      degenerate;
  } normal_t;

endpackage

### rtl/core/triangle_unit_normal.sv
// Top level of the triangle unit normal block: edge vectors, lanes, merge, square root, divide and output.
//
//   channel  | valid         | stall         | payload
//   request  | vertex_valid  | vertex_stall  | vertex (vertex_t)
//   result   | normal_valid  | normal_stall  | normal (normal_t)
//
// One request per cycle while the result side does not stall; the square root and
// divider pipelines each resolve one bit per stage.
// No state beyond the pipeline; reset clears only the valid bits.
// A stalled result freezes the whole pipeline, and the request side stalls with it.
module triangle_unit_normal import tun_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int NORMAL_FRAC = NORMAL_FRAC_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    vertex_valid,
  output logic    vertex_stall,
  input  vertex_t vertex,
  output logic    normal_valid,
  input  logic    normal_stall,
  output normal_t normal
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int MW  = 2 * COORD_WIDTH + 1;
  localparam int RW  = MW + 1;
  localparam int QW  = NORMAL_FRAC + 2;
  localparam int EW  = (COORD_WIDTH > FIELD_W) ? COORD_WIDTH : FIELD_W;
  localparam int VW  = (QW + 1 > FIELD_W) ? QW + 1 : FIELD_W;
  localparam int D   = 6 + RW + QW;
  localparam int MDL = 1 + RW;
  localparam int SDL = RW + QW;

  function automatic logic signed [COORD_WIDTH-1:0] coord(input logic [FIELD_W-1:0] f);
    logic [EW-1:0] e;
    e = EW'(f);
    return e[COORD_WIDTH-1:0];
  endfunction

  function automatic logic [FIELD_W-1:0] signed_out(input logic [QW-1:0] q, input logic ng);
    logic [VW-1:0] c;
    c = (q > (QW'(1) << NORMAL_FRAC)) ? (VW'(1) << NORMAL_FRAC) : VW'(q);
    if (ng) begin
      c = ~c + 1'b1;
    end
    return c[FIELD_W-1:0];
  endfunction

  logic                   en;
  logic signed [DW-1:0]   u [3];
  logic signed [DW-1:0]   v [3];
  logic signed [COORD_WIDTH-1:0] pa [3];
  logic signed [COORD_WIDTH-1:0] pb [3];
  logic signed [COORD_WIDTH-1:0] pc [3];
  logic [MW-1:0]          mag [3];
  logic [2:0]             neg;
  logic [2*MW-1:0]        sq [3];
  logic [2*RW-1:0]        sum;
  logic                   zero;
  logic [2:0]             neg1;
  logic [RW-1:0]          root;
  logic [3*MW-1:0]        md [MDL];
  logic [3:0]             sd [SDL];
  logic [QW-1:0]          quo [3];
  logic [D-1:0]           vld;

  assign en           = !(normal_valid && normal_stall);
  assign vertex_stall = normal_valid && normal_stall;

  assign pa[0] = coord(vertex.first_x);
  assign pa[1] = coord(vertex.first_y);
  assign pa[2] = coord(vertex.first_z);
  assign pb[0] = coord(vertex.second_x);
  assign pb[1] = coord(vertex.second_y);
  assign pb[2] = coord(vertex.second_z);
  assign pc[0] = coord(vertex.third_x);
  assign pc[1] = coord(vertex.third_y);
  assign pc[2] = coord(vertex.third_z);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u[i] <= DW'(pb[i]) - DW'(pa[i]);
        v[i] <= DW'(pc[i]) - DW'(pb[i]);
      end
    end
  end

  tun_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_x (
    .clk(clk), .en(en), .a(u[1]), .b(v[2]), .c(u[2]), .d(v[1]),
    .mag(mag[0]), .neg(neg[0]), .sq(sq[0])
  );

  tun_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_y (
    .clk(clk), .en(en), .a(u[2]), .b(v[0]), .c(u[0]), .d(v[2]),
    .mag(mag[1]), .neg(neg[1]), .sq(sq[1])
  );

  tun_cross #(.COORD_WIDTH(COORD_WIDTH)) u_cross_z (
    .clk(clk), .en(en), .a(u[0]), .b(v[1]), .c(u[1]), .d(v[0]),
    .mag(mag[2]), .neg(neg[2]), .sq(sq[2])
  );

  // merge the lanes: squared length and zero test
  always_ff @(posedge clk) begin
    if (en) begin
      sum  <= (2*RW)'(sq[0]) + (2*RW)'(sq[1]) + (2*RW)'(sq[2]);
      zero <= (mag[0] == '0) && (mag[1] == '0) && (mag[2] == '0);
      neg1 <= neg;
      md[0] <= {mag[0], mag[1], mag[2]};
      sd[0] <= {zero, neg1};
      for (int k = 1; k < MDL; k++) begin
        md[k] <= md[k-1];
      end
      for (int k = 1; k < SDL; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  tun_sqrt #(.ROOT_W(RW)) u_sqrt (
    .clk(clk), .en(en), .rad(sum), .root(root)
  );

  for (genvar i = 0; i < 3; i++) begin : g_div
    tun_div #(.NUM_W(MW), .ROOT_W(RW), .FRAC(NORMAL_FRAC)) u_div (
      .clk(clk), .en(en), .mag(md[MDL-1][(2-i)*MW +: MW]), .root(root), .quo(quo[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      normal_valid <= 1'b0;
    end else if (en) begin
      vld          <= {vld[D-2:0], vertex_valid};
      normal_valid <= vld[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      normal.degenerate <= sd[SDL-1][3];
      normal.normal_x   <= sd[SDL-1][3] ? '0 : signed_out(quo[0], sd[SDL-1][0]);
      normal.normal_y   <= sd[SDL-1][3] ? '0 : signed_out(quo[1], sd[SDL-1][1]);
      normal.normal_z   <= sd[SDL-1][3] ? '0 : signed_out(quo[2], sd[SDL-1][2]);
    end
  end

`ifndef SYNTHESIS
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    normal_valid && normal.degenerate |->
      normal.normal_x == '0 && normal.normal_y == '0 && normal.normal_z == '0)
    else $error("degenerate result carries a nonzero normal");

  a_normal_nonzero: assert property (@(posedge clk) disable iff (rst)
    (NORMAL_FRAC < FIELD_W - 1) && normal_valid && !normal.degenerate |->
      normal.normal_x != '0 || normal.normal_y != '0 || normal.normal_z != '0)
    else $error("regular triangle produced an all-zero normal");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !normal_valid && vld == '0)
    else $error("pipeline holds a valid result after reset");
`endif

endmodule

### rtl/core/tun_cross.sv
// One cross product lane: component, its magnitude and sign, and its square.
module tun_cross import tun_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COORD_WIDTH:0]  a,
  input  logic signed [COORD_WIDTH:0]  b,
  input  logic signed [COORD_WIDTH:0]  c,
  input  logic signed [COORD_WIDTH:0]  d,
  output logic [2*COORD_WIDTH:0]       mag,
  output logic                         neg,
  output logic [4*COORD_WIDTH+1:0]     sq
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int PW = 2 * DW;
  localparam int TW = PW + 1;
  localparam int MW = 2 * COORD_WIDTH + 1;
  localparam int HW = (MW + 1) / 2;
  localparam int LW = MW - HW;
  localparam int SW = 2 * MW;

  logic signed [PW-1:0] p;
  logic signed [PW-1:0] q;
  logic signed [TW-1:0] t;
  logic [TW-1:0]        ta;
  logic [MW-1:0]        m2;
  logic                 neg2;
  logic [MW-1:0]        m3;
  logic                 neg3;
  logic [2*HW-1:0]      hh;
  logic [HW+LW-1:0]     hl;
  logic [2*LW-1:0]      ll;

  assign t  = TW'(p) - TW'(q);
  assign ta = t[TW-1] ? (~t + 1'b1) : t;

  always_ff @(posedge clk) begin
    if (en) begin
      p    <= a * b;
      q    <= c * d;
      m2   <= ta[MW-1:0];
      neg2 <= t[TW-1];
      hh   <= m2[MW-1:LW] * m2[MW-1:LW];
      hl   <= m2[MW-1:LW] * m2[LW-1:0];
      ll   <= m2[LW-1:0] * m2[LW-1:0];
      m3   <= m2;
      neg3 <= neg2;
      sq   <= (SW'(hh) << (2 * LW)) + (SW'(hl) << (LW + 1)) + SW'(ll);
      mag  <= m3;
      neg  <= neg3;
    end
  end

endmodule

### rtl/core/tun_sqrt.sv
// Pipelined floor square root, one root bit per stage.
module tun_sqrt import tun_pkg::*; #(
  parameter int ROOT_W = 2 * COORD_WIDTH_DEF + 2
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2*ROOT_W-1:0]   rad,
  output logic [ROOT_W-1:0]     root
);

  localparam int RAD_W = 2 * ROOT_W;

  logic [ROOT_W-1:0] rt [ROOT_W];
  logic [RAD_W-1:0]  rm [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [ROOT_W-1:0] r_in;
    logic [RAD_W-1:0]  x_in;
    logic [RAD_W-1:0]  trial;
    logic              take;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign x_in = rad;
    end else begin : g_next
      assign r_in = rt[k-1];
      assign x_in = rm[k-1];
    end

    assign trial = (RAD_W'(r_in) << (B + 1)) | (RAD_W'(1) << (2 * B));
    assign take  = (x_in >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rt[k] <= take ? (r_in | (ROOT_W'(1) << B)) : r_in;
        rm[k] <= take ? (x_in - trial) : x_in;
      end
    end
  end

  assign root = rt[ROOT_W-1];

endmodule

### rtl/core/tun_div.sv
// Pipelined restoring divider for one normal component, one quotient bit per stage.
module tun_div import tun_pkg::*; #(
  parameter int NUM_W  = 2 * COORD_WIDTH_DEF + 1,
  parameter int ROOT_W = 2 * COORD_WIDTH_DEF + 2,
  parameter int FRAC   = NORMAL_FRAC_DEF
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NUM_W-1:0]    mag,
  input  logic [ROOT_W-1:0]   root,
  output logic [FRAC+1:0]     quo
);

  localparam int QW = FRAC + 2;
  localparam int XW = ROOT_W + QW - 1;

  logic [XW-1:0]     rm [QW];
  logic [QW-1:0]     qt [QW];
  logic [ROOT_W-1:0] rt [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [XW-1:0]     x_in;
    logic [QW-1:0]     q_in;
    logic [ROOT_W-1:0] r_in;
    logic [XW-1:0]     dv;
    logic              take;

    if (k == 0) begin : g_first
      assign x_in = XW'(mag) << FRAC;
      assign q_in = '0;
      assign r_in = root;
    end else begin : g_next
      assign x_in = rm[k-1];
      assign q_in = qt[k-1];
      assign r_in = rt[k-1];
    end

    assign dv   = XW'(r_in) << B;
    assign take = (x_in >= dv);

    always_ff @(posedge clk) begin
      if (en) begin
        rm[k] <= take ? (x_in - dv) : x_in;
        qt[k] <= take ? (q_in | (QW'(1) << B)) : q_in;
        rt[k] <= r_in;
      end
    end
  end

  assign quo = qt[QW-1];

endmodule
